@@ rtl/pfe_pkg.sv @@
`timescale 1ns / 1ps

package pfe_pkg;

	localparam int SAMPLE_BITS_DEF = 11;
	localparam int MAX_SAMPLES_DEF = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int THR_W      = 12;
	localparam int WIN_W      = 10;
	localparam int PER_W      = 4;
	localparam int INT_W      = 22;
	localparam int DIV_W      = WIN_W + 1;

	localparam logic signed [THR_W-1:0] THR_A_RST = '0;
	localparam logic signed [THR_W-1:0] THR_B_RST = '0;
	localparam logic [WIN_W-1:0] WIN_START_RST = 10'd100;
	localparam logic [WIN_W-1:0] WIN_END_RST   = 10'd200;
	localparam logic [PER_W-1:0] PERIOD_RST    = 4'd3;
	localparam logic [PER_W-1:0] PHASE_RST     = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THR_A     = 3'd0,
		CFG_THR_B     = 3'd1,
		CFG_WIN_START = 3'd2,
		CFG_WIN_END   = 3'd3,
		CFG_PERIOD    = 3'd4,
		CFG_PHASE     = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		CMD_SAMPLE   = 1'b0,
		CMD_BOUNDARY = 1'b1
	} item_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_PEDESTAL,
		ST_MULTIPLY,
		ST_EMIT
	} pfe_state_t;

	typedef struct packed {
		logic acc;
		logic clr;
		logic div_load;
		logic div_step;
		logic ped_load;
		logic mul_load;
		logic finish;
	} pfe_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_busy;
	} pfe_status_t;

endpackage

@@ rtl/pfe_if.sv @@
`timescale 1ns / 1ps

interface pfe_in_if import pfe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [SAMPLE_BITS-1:0] sample_a;
	logic signed [SAMPLE_BITS-1:0] sample_b;

	modport source (output valid, cmd, sample_a, sample_b, input ready);
	modport sink   (input valid, cmd, sample_a, sample_b, output ready);
endinterface

interface pfe_out_if import pfe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) ();
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pedestal_a;
	logic signed [SAMPLE_BITS-1:0] pedestal_b;
	logic signed [SAMPLE_BITS:0]   amplitude_a;
	logic signed [SAMPLE_BITS:0]   amplitude_b;
	logic signed [INT_W-1:0]       integral_a;
	logic signed [INT_W-1:0]       integral_b;
	logic signed [SAMPLE_BITS-1:0] peak_max_a;
	logic signed [SAMPLE_BITS-1:0] peak_max_b;
	logic signed [SAMPLE_BITS-1:0] peak_min_a;
	logic signed [SAMPLE_BITS-1:0] peak_min_b;
	logic [CNT_W-1:0]              sample_count;

	modport source (output valid, pedestal_a, pedestal_b, amplitude_a, amplitude_b,
		integral_a, integral_b, peak_max_a, peak_max_b, peak_min_a, peak_min_b,
		sample_count, input ready);
	modport sink (input valid, pedestal_a, pedestal_b, amplitude_a, amplitude_b,
		integral_a, integral_b, peak_max_a, peak_max_b, peak_min_a, peak_min_b,
		sample_count, output ready);
endinterface

@@ rtl/pfe_ctrl.sv @@
`timescale 1ns / 1ps

module pfe_ctrl import pfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_cmd,
	input  logic [PER_W-1:0] period,
	input  logic [PER_W-1:0] phase,
	input  pfe_status_t      stat,
	output logic             item_ready,
	output pfe_cmd_t         ctrl
);

	pfe_state_t       state_q, state_nxt;
	logic             first_q;
	logic [PER_W-1:0] residue_q;
	logic             accept, is_bnd, selected;
	logic [PER_W:0]   residue_inc, period_eff;

	assign accept   = item_valid && (state_q == ST_IDLE);
	assign is_bnd   = (item_cmd == CMD_BOUNDARY);
	assign selected = !first_q && (residue_q == phase);

	// a zero period behaves as one
	assign residue_inc = {1'b0, residue_q} + 1'b1;
	assign period_eff  = (period == '0) ? (PER_W+1)'(1) : {1'b0, period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			first_q   <= 1'b1;
			residue_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && is_bnd) begin
				first_q   <= 1'b0;
				residue_q <= (residue_inc >= period_eff) ? '0 : residue_inc[PER_W-1:0];
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (accept && is_bnd && selected) state_nxt = ST_DIVIDE;
			ST_DIVIDE:   if (stat.div_last) state_nxt = ST_PEDESTAL;
			ST_PEDESTAL: state_nxt = ST_MULTIPLY;
			ST_MULTIPLY: state_nxt = ST_EMIT;
			ST_EMIT:     if (!stat.out_busy) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl       = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready    = 1'b1;
				ctrl.acc      = accept && !is_bnd;
				ctrl.clr      = accept && is_bnd && !selected;
				ctrl.div_load = accept && is_bnd && selected;
			end
			ST_DIVIDE:   ctrl.div_step = 1'b1;
			ST_PEDESTAL: ctrl.ped_load = 1'b1;
			ST_MULTIPLY: ctrl.mul_load = 1'b1;
			ST_EMIT:     ctrl.finish   = !stat.out_busy;
			default:     ctrl = '0;
		endcase
	end

endmodule

@@ rtl/pfe_datapath.sv @@
`timescale 1ns / 1ps

module pfe_datapath import pfe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pfe_cmd_t                             ctrl,
	output pfe_status_t                          stat,
	input  logic signed [SAMPLE_BITS-1:0]        sample_a,
	input  logic signed [SAMPLE_BITS-1:0]        sample_b,
	input  logic signed [THR_W-1:0]              thr_a,
	input  logic signed [THR_W-1:0]              thr_b,
	input  logic [WIN_W-1:0]                     win_start,
	input  logic [WIN_W-1:0]                     win_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        pedestal_a,
	output logic signed [SAMPLE_BITS-1:0]        pedestal_b,
	output logic signed [SAMPLE_BITS:0]          amplitude_a,
	output logic signed [SAMPLE_BITS:0]          amplitude_b,
	output logic signed [INT_W-1:0]              integral_a,
	output logic signed [INT_W-1:0]              integral_b,
	output logic signed [SAMPLE_BITS-1:0]        peak_max_a,
	output logic signed [SAMPLE_BITS-1:0]        peak_max_b,
	output logic signed [SAMPLE_BITS-1:0]        peak_min_a,
	output logic signed [SAMPLE_BITS-1:0]        peak_min_b,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]     sample_count
);

	localparam int SB     = SAMPLE_BITS;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
	localparam int AMP_W  = SAMPLE_BITS + 1;
	localparam int PROD_W = SAMPLE_BITS + CNT_W + 1;
	localparam int DIFF_W = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
	localparam int SAT_W  = (DIFF_W > INT_W) ? DIFF_W : INT_W;
	localparam int CMP_W  = (AMP_W > THR_W) ? AMP_W : THR_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int WCMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

	localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [SAT_W-1:0] SAT_HI =
		{{(SAT_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_LO =
		{{(SAT_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}};

	logic signed [SB-1:0]     smp    [2];
	logic signed [SB-1:0]     min_q  [2];
	logic signed [SB-1:0]     max_q  [2];
	logic signed [SUM_W-1:0]  sum_q  [2];
	logic signed [SUM_W-1:0]  wsum_q [2];
	logic [CNT_W-1:0]         count_q;

	logic [SUM_W-1:0]         quo_q  [2];
	logic [DIV_W-1:0]         rem_q  [2];
	logic                     neg_q  [2];
	logic [DIV_W-1:0]         dvsr_q;
	logic                     wzero_q;
	logic [STEP_W-1:0]        step_q;

	logic signed [SB-1:0]     ped_s1  [2];
	logic signed [PROD_W-1:0] prod_s2 [2];
	logic signed [AMP_W-1:0]  amp_s2  [2];

	logic                     full, in_win, wzero, pass;
	logic [DIV_W-1:0]         wcount;
	logic [SUM_W-1:0]         mag   [2];
	logic [DIV_W:0]           rs    [2];
	logic [DIV_W:0]           rsub  [2];
	logic                     ge    [2];
	logic [SUM_W-1:0]         qn    [2];
	logic signed [SAT_W-1:0]  diff  [2];
	logic signed [INT_W-1:0]  integ [2];
	logic                     thr_ok[2];

	assign smp[0] = sample_a;
	assign smp[1] = sample_b;

	assign full   = (count_q == CNT_W'(MAX_SAMPLES));
	assign in_win = (WCMP_W'(count_q) >= WCMP_W'(win_start)) &&
	                (WCMP_W'(count_q) <= WCMP_W'(win_end));
	assign wzero  = (win_end < win_start);
	assign wcount = {1'b0, win_end} - {1'b0, win_start} + 1'b1;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			mag[c]  = wsum_q[c][SUM_W-1] ? (~wsum_q[c] + 1'b1) : wsum_q[c];
			rs[c]   = {rem_q[c], quo_q[c][SUM_W-1]};
			rsub[c] = rs[c] - {1'b0, dvsr_q};
			ge[c]   = (rs[c] >= {1'b0, dvsr_q});
			qn[c]   = neg_q[c] ? (~quo_q[c] + 1'b1) : quo_q[c];
			diff[c] = SAT_W'(sum_q[c]) - SAT_W'(prod_s2[c]);
			if (diff[c] > SAT_HI)
				integ[c] = SAT_HI[INT_W-1:0];
			else if (diff[c] < SAT_LO)
				integ[c] = SAT_LO[INT_W-1:0];
			else
				integ[c] = diff[c][INT_W-1:0];
		end
		thr_ok[0] = (CMP_W'(amp_s2[0]) > CMP_W'(thr_a));
		thr_ok[1] = (CMP_W'(amp_s2[1]) > CMP_W'(thr_b));
		pass      = thr_ok[0] && thr_ok[1];
	end

	assign stat.div_last = (step_q == '0);
	assign stat.out_busy = out_valid && !out_ready;

	// record accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int c = 0; c < 2; c++) begin
				min_q[c]  <= SMP_MAX;
				max_q[c]  <= SMP_MIN;
				sum_q[c]  <= '0;
				wsum_q[c] <= '0;
			end
		end else if (ctrl.clr || ctrl.finish) begin
			count_q <= '0;
			for (int c = 0; c < 2; c++) begin
				min_q[c]  <= SMP_MAX;
				max_q[c]  <= SMP_MIN;
				sum_q[c]  <= '0;
				wsum_q[c] <= '0;
			end
		end else if (ctrl.acc && !full) begin
			count_q <= count_q + 1'b1;
			for (int c = 0; c < 2; c++) begin
				if (smp[c] < min_q[c]) min_q[c] <= smp[c];
				if (smp[c] > max_q[c]) max_q[c] <= smp[c];
				sum_q[c] <= sum_q[c] + SUM_W'(smp[c]);
				if (in_win) wsum_q[c] <= wsum_q[c] + SUM_W'(smp[c]);
			end
		end
	end

	// restoring divider, one quotient bit per lane per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctrl.div_load) begin
			step_q <= STEP_W'(SUM_W - 1);
		end else if (ctrl.div_step) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			dvsr_q  <= wcount;
			wzero_q <= wzero;
			for (int c = 0; c < 2; c++) begin
				quo_q[c] <= mag[c];
				rem_q[c] <= '0;
				neg_q[c] <= wsum_q[c][SUM_W-1];
			end
		end else if (ctrl.div_step) begin
			for (int c = 0; c < 2; c++) begin
				quo_q[c] <= {quo_q[c][SUM_W-2:0], ge[c]};
				rem_q[c] <= ge[c] ? rsub[c][DIV_W-1:0] : rs[c][DIV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 2; c++) begin
			if (ctrl.ped_load)
				ped_s1[c] <= wzero_q ? '0 : qn[c][SB-1:0];
			if (ctrl.mul_load) begin
				prod_s2[c] <= PROD_W'(ped_s1[c]) * PROD_W'($signed({1'b0, count_q}));
				amp_s2[c]  <= AMP_W'(max_q[c]) - AMP_W'(ped_s1[c]);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ctrl.finish && pass)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish && pass) begin
			pedestal_a   <= ped_s1[0];
			pedestal_b   <= ped_s1[1];
			amplitude_a  <= amp_s2[0];
			amplitude_b  <= amp_s2[1];
			integral_a   <= integ[0];
			integral_b   <= integ[1];
			peak_max_a   <= max_q[0];
			peak_max_b   <= max_q[1];
			peak_min_a   <= min_q[0];
			peak_min_b   <= min_q[1];
			sample_count <= count_q;
		end
	end

endmodule

@@ rtl/pulse_feature_extractor_core.sv @@
`timescale 1ns / 1ps

// Two-channel pulse feature extractor. Sample requests (cmd 0) are taken one
// per clock while the block is idle and update per-channel min, max, total
// sum and the sum over the inclusive pedestal window of sample indices;
// samples past MAX_SAMPLES in a record are dropped. A boundary request (cmd 1)
// closes the record. An unselected boundary clears the record. A selected one
// (record counter nonzero and counter mod record_period == record_phase)
// occupies the block, with input ready low from the accept until the block
// is idle again: the accept cycle loads the bit-serial pedestal divider,
// which then retires one quotient bit per cycle, followed by the pedestal,
// multiply and emit states; the emit state waits while a previous result is
// still unclaimed. A result is issued only when both amplitudes exceed their
// thresholds, and sits in an output register so new samples flow while it
// waits. Write configuration only while the block is idle. There is no memory
// and no clearing pass.

module pulse_feature_extractor_core import pfe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pfe_in_if.sink                item,
	pfe_out_if.source             result
);

	// configuration registers
	logic signed [THR_W-1:0] thr_a_q, thr_b_q;
	logic [WIN_W-1:0]        win_start_q, win_end_q;
	logic [PER_W-1:0]        period_q, phase_q;

	pfe_cmd_t    ctrl;
	pfe_status_t stat;

	// unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_a_q     <= THR_A_RST;
			thr_b_q     <= THR_B_RST;
			win_start_q <= WIN_START_RST;
			win_end_q   <= WIN_END_RST;
			period_q    <= PERIOD_RST;
			phase_q     <= PHASE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THR_A:     thr_a_q     <= cfg_wdata[THR_W-1:0];
				CFG_THR_B:     thr_b_q     <= cfg_wdata[THR_W-1:0];
				CFG_WIN_START: win_start_q <= cfg_wdata[WIN_W-1:0];
				CFG_WIN_END:   win_end_q   <= cfg_wdata[WIN_W-1:0];
				CFG_PERIOD:    period_q    <= cfg_wdata[PER_W-1:0];
				CFG_PHASE:     phase_q     <= cfg_wdata[PER_W-1:0];
				default:       ;
			endcase
		end
	end

	// sequencer: accepts requests, tracks the record counter, steps the datapath
	pfe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_cmd   (item.cmd),
		.period     (period_q),
		.phase      (phase_q),
		.stat       (stat),
		.item_ready (item.ready),
		.ctrl       (ctrl)
	);

	// accumulators, divider, multiplier and the result register
	pfe_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.sample_a     (item.sample_a),
		.sample_b     (item.sample_b),
		.thr_a        (thr_a_q),
		.thr_b        (thr_b_q),
		.win_start    (win_start_q),
		.win_end      (win_end_q),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.pedestal_a   (result.pedestal_a),
		.pedestal_b   (result.pedestal_b),
		.amplitude_a  (result.amplitude_a),
		.amplitude_b  (result.amplitude_b),
		.integral_a   (result.integral_a),
		.integral_b   (result.integral_b),
		.peak_max_a   (result.peak_max_a),
		.peak_max_b   (result.peak_max_b),
		.peak_min_a   (result.peak_min_a),
		.peak_min_b   (result.peak_min_b),
		.sample_count (result.sample_count)
	);

endmodule

@@ rtl/pfe_checker.sv @@
`timescale 1ns / 1ps

module pfe_checker import pfe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 item_valid,
	input logic                                 item_ready,
	input logic                                 item_cmd,
	input logic                                 result_valid,
	input logic                                 result_ready,
	input logic signed [SAMPLE_BITS-1:0]        result_pedestal_a,
	input logic signed [SAMPLE_BITS:0]          result_amplitude_a,
	input logic signed [INT_W-1:0]              result_integral_a,
	input logic signed [SAMPLE_BITS-1:0]        result_peak_max_a,
	input logic signed [SAMPLE_BITS-1:0]        result_peak_min_a,
	input logic [$clog2(MAX_SAMPLES+1)-1:0]     result_sample_count
);

	localparam int SB    = SAMPLE_BITS;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_integral_a) && $stable(result_amplitude_a))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_amplitude_a ==
			({result_peak_max_a[SB-1], result_peak_max_a} -
			 {result_pedestal_a[SB-1], result_pedestal_a}))
		else $error("amplitude is not max minus pedestal");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_sample_count <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond record limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_sample_count != '0) |->
			result_peak_min_a <= result_peak_max_a)
		else $error("minimum above maximum in a nonempty record");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_ready) |-> $past(item_valid && (item_cmd == CMD_BOUNDARY)))
		else $error("input stalled without a boundary");

endmodule

bind pulse_feature_extractor_core pfe_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.MAX_SAMPLES (MAX_SAMPLES)
) u_pfe_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.item_cmd            (item.cmd),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_pedestal_a   (result.pedestal_a),
	.result_amplitude_a  (result.amplitude_a),
	.result_integral_a   (result.integral_a),
	.result_peak_max_a   (result.peak_max_a),
	.result_peak_min_a   (result.peak_min_a),
	.result_sample_count (result.sample_count)
);
